// ===== hw/rtl/vrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_pkg
// constants and types for the velocity rescale thermostat
// ----------------------------------------------------------------------------
package vrt_pkg;
	localparam int MaxParticles = 64;
	localparam int VelW = 32;

	localparam logic [2:0] REG_T0  = 3'd0;
	localparam logic [2:0] REG_DT  = 3'd1;
	localparam logic [2:0] REG_TAU = 3'd2;
	localparam logic [2:0] REG_ES  = 3'd3;
	localparam logic [2:0] REG_KB  = 3'd4;

	typedef enum logic [3:0] {
		ST_LOAD, ST_TNUM, ST_TDIV, ST_TDONE, ST_QSET, ST_QGO, ST_QDIV, ST_RAD, ST_SQRT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic [127:0] num;
		logic [63:0] den;
	} div_req_t;

	// scale one velocity by a q16.16 factor, saturating
	function automatic logic [31:0] scale_vel(input logic [31:0] v, input logic [31:0] f);
		logic [31:0] m;
		logic [63:0] p;
		logic [47:0] s;
		m = v[31] ? (~v + 32'd1) : v;
		p = m * f;
		s = p[63:16];
		if (!v[31]) scale_vel = (s > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : s[31:0];
		else if (s >= 48'h8000_0000) scale_vel = 32'h8000_0000;
		else scale_vel = ~s[31:0] + 32'd1;
	endfunction
endpackage

// ===== hw/rtl/vrt_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_stream_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface vrt_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/velocity_rescale_thermostat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_rescale_thermostat
// berendsen thermostat: load particles, compute factor, emit scaled velocities
// ----------------------------------------------------------------------------
// load: one item per cycle, energy term folded in over a 2-stage pipe
// on the last item: compute waits for the energy sum to settle, then runs two
// serial divides and a serial square root, with setup states between them
// emit: one per cycle from the ram while not stalled, via read and output regs
// the ram read is registered; output register holds under stall
// reset clears control, energy sum and count; ram contents stay undefined
module velocity_rescale_thermostat
	import vrt_pkg::*;
#(
	parameter int MAX_PARTICLES = MaxParticles
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [47:0] cfg_data,
	vrt_stream_if.sink in_ch,
	vrt_stream_if.source out_ch
);
	localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int NW = CW + 2;

	// configuration registers
	logic [31:0] t0_q, dt_q, tau_q, es_q;
	logic [47:0] kb_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t0_q <= 32'd19660800;
			dt_q <= 32'd65536;
			tau_q <= 32'd6553600;
			es_q <= 32'd65536;
			kb_q <= 48'd24254720000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_T0: t0_q <= cfg_data[31:0];
				REG_DT: dt_q <= cfg_data[31:0];
				REG_TAU: tau_q <= cfg_data[31:0];
				REG_ES: es_q <= cfg_data[31:0];
				REG_KB: kb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input payload: mass, vx, vy, vz, is_last
	logic [31:0] in_mass, in_vx, in_vy, in_vz;
	logic in_last;
	assign {in_mass, in_vx, in_vy, in_vz, in_last} = in_ch.data;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, emit_q;
	logic [63:0] esum_q;
	logic take, store_ok;
	assign take = in_ch.valid && in_ch.ready;
	assign store_ok = count_q < CW'(MAX_PARTICLES);

	// velocity ram: one write port on load, one registered read port on emit
	logic [95:0] vel_mem [MAX_PARTICLES];
	logic [95:0] rd_q;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	always_ff @(posedge clk) begin
		if (take && store_ok) vel_mem[count_q[AW-1:0]] <= {in_vx, in_vy, in_vz};
		if (rd_en) rd_q <= vel_mem[rd_addr];
	end

	// energy pipe: s1 squares, s2 mass product
	logic [63:0] vsq_s1;
	logic [31:0] mass_s1;
	logic v_s1, v_s2;
	logic [63:0] term_s2;
	logic [31:0] mx, my, mz;
	logic [63:0] sqx, sqy, sqz;
	logic [65:0] vsq_w;
	logic [63:0] mp_lo, mp_hi;
	logic [95:0] mp;
	assign mx = in_vx[31] ? (~in_vx + 32'd1) : in_vx;
	assign my = in_vy[31] ? (~in_vy + 32'd1) : in_vy;
	assign mz = in_vz[31] ? (~in_vz + 32'd1) : in_vz;
	assign sqx = mx * mx;
	assign sqy = my * my;
	assign sqz = mz * mz;
	assign vsq_w = {2'b0, sqx} + {2'b0, sqy} + {2'b0, sqz};
	// mass times vsq as two 32x32 partial products
	assign mp_lo = vsq_s1[31:0] * mass_s1;
	assign mp_hi = vsq_s1[63:32] * mass_s1;
	assign mp = {32'd0, mp_lo} + {mp_hi, 32'd0};
	// three squares of at most 2^62 always fit 64 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take && store_ok;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		vsq_s1 <= vsq_w[63:0];
		mass_s1 <= in_mass;
		term_s2 <= (mp[95:81] != 15'd0) ? '1 : mp[80:17];
	end
	logic [64:0] esum_add;
	assign esum_add = {1'b0, esum_q} + {1'b0, term_s2};

	// divider shared by both divides, and the square root unit
	div_req_t dreq;
	logic dbusy, sbusy, sstart;
	logic [63:0] dquo;
	logic [31:0] sroot;
	logic [63:0] fac_q_unused_guard;
	assign fac_q_unused_guard = '0;
	logic [31:0] temp_q, d_q;
	logic up_q, zt_q, fail_q;
	logic [31:0] fac_q;
	logic [63:0] rad_q;
	logic [127:0] num_q;
	logic [63:0] den_q;
	vrt_divider u_div (.clk, .arst_n, .req(dreq), .busy(dbusy), .quo(dquo));
	vrt_sqrt u_sqrt (.clk, .arst_n, .start(sstart), .x(rad_q), .busy(sbusy), .root(sroot));

	// energy times scale as two 32x32 partial products
	logic [63:0] pe_lo, pe_hi;
	logic [95:0] pe;
	logic [NW-1:0] n3;
	logic [47+NW:0] pt;
	logic up_w;
	logic [31:0] d_w;
	logic [63:0] pq;
	assign pe_lo = esum_q[31:0] * es_q;
	assign pe_hi = esum_q[63:32] * es_q;
	assign pe = {32'd0, pe_lo} + {pe_hi, 32'd0};
	assign n3 = NW'(count_q) * NW'(3);
	assign pt = kb_q * n3;
	assign up_w = t0_q >= temp_q;
	assign d_w = up_w ? (t0_q - temp_q) : (temp_q - t0_q);
	assign pq = dt_q * d_w;

	// output register
	logic ov_q;
	logic [97:0] od_q;
	logic adv;
	assign out_ch.valid = ov_q;
	assign out_ch.data = od_q;
	assign adv = !ov_q || out_ch.ready;

	logic rdv_q;
	assign in_ch.ready = (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (take && in_last) state_d = ST_TNUM;
			ST_TNUM: if (!v_s1 && !v_s2) state_d = ST_TDIV;
			ST_TDIV: state_d = ST_TDONE;
			ST_TDONE: if (!dbusy) state_d = ST_QSET;
			ST_QSET: state_d = ST_QGO;
			ST_QGO: state_d = ST_QDIV;
			ST_QDIV: if (!dbusy) state_d = ST_RAD;
			ST_RAD: state_d = ST_SQRT;
			ST_SQRT: if (!sbusy && !sstart) state_d = ST_EMIT;
			ST_EMIT: if (emit_q == count_q && !rdv_q && adv) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = num_q;
		dreq.den = den_q;
		sstart = 1'b0;
		rd_en = 1'b0;
		rd_addr = emit_q[AW-1:0];
		case (state_q)
			ST_TDIV: dreq.start = 1'b1;
			ST_QGO: dreq.start = 1'b1;
			ST_RAD: sstart = 1'b1;
			ST_EMIT: rd_en = adv && (emit_q != count_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			esum_q <= '0;
			emit_q <= '0;
			rdv_q <= 1'b0;
			ov_q <= 1'b0;
			zt_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take && store_ok) count_q <= count_q + CW'(1);
			if (v_s2) esum_q <= esum_add[64] ? '1 : esum_add[63:0];
			if (out_ch.ready) ov_q <= 1'b0;
			case (state_q)
				ST_TDONE: if (!dbusy) begin
					zt_q <= (num_q == '0) || (dquo == 64'd0);
				end
				ST_EMIT: begin
					if (adv) begin
						rdv_q <= rd_en;
						if (rd_en) emit_q <= emit_q + CW'(1);
						if (rdv_q) ov_q <= 1'b1;
					end
					if (state_d == ST_LOAD) begin
						count_q <= '0;
						esum_q <= '0;
						emit_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_TNUM: begin
				num_q <= {15'd0, pe, 17'd0};
				den_q <= {{(16-NW){1'b0}}, pt};
			end
			ST_TDONE: if (!dbusy) begin
				temp_q <= (num_q == '0) ? 32'd0 : ((dquo > 64'hFFFF_FFFF) ? '1 : dquo[31:0]);
			end
			ST_QSET: begin
				up_q <= up_w;
				d_q <= d_w;
				den_q <= tau_q * temp_q;
				num_q <= {32'd0, pq, 32'd0};
			end
			default: ;
		endcase
		if (state_q == ST_QDIV && !dbusy) begin
			if (d_q == 32'd0) begin
				rad_q <= 64'h1_0000_0000;
				fail_q <= 1'b0;
			end else if (up_q) begin
				rad_q <= (dquo > 64'hFFFF_FFFE_FFFF_FFFF) ? '1 : dquo + 64'h1_0000_0000;
				fail_q <= 1'b0;
			end else begin
				rad_q <= 64'h1_0000_0000 - dquo;
				fail_q <= dquo >= 64'h1_0000_0000;
			end
		end
		if (state_q == ST_SQRT && !sbusy) fac_q <= fail_q ? 32'd0 : sroot;
		if (state_q == ST_EMIT && adv && rdv_q) begin
			od_q[97:66] <= zt_q ? rd_q[95:64] : scale_vel(rd_q[95:64], fac_q);
			od_q[65:34] <= zt_q ? rd_q[63:32] : scale_vel(rd_q[63:32], fac_q);
			od_q[33:2] <= zt_q ? rd_q[31:0] : scale_vel(rd_q[31:0], fac_q);
			od_q[1] <= (emit_q == count_q) && !rd_en;
			od_q[0] <= zt_q;
		end
	end

	// the ram is only written while loading
	a_store_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		(take && store_ok) |-> (state_q == ST_LOAD)) else $error("store outside load");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PARTICLES)) else $error("count overflow");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q <= count_q) else $error("emit past count");
	a_no_out_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && $past(state_q) == ST_LOAD) |-> !rdv_q)
		else $error("read pending in load");
endmodule

// ===== hw/rtl/vrt_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_divider
// restoring divider, 128 by 64 bits, one quotient bit per cycle, saturating
// ----------------------------------------------------------------------------
module vrt_divider
	import vrt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  div_req_t req,
	output logic busy,
	output logic [63:0] quo
);
	logic [127:0] num_q, qt_q;
	logic [63:0] rem_q, den_q;
	logic [7:0] cnt_q;
	logic [64:0] sh;
	logic ge;

	assign sh = {rem_q, num_q[127]};
	assign ge = sh[64] || (sh[63:0] >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy <= 1'b1;
			cnt_q <= 8'd128;
		end else if (busy) begin
			cnt_q <= cnt_q - 8'd1;
			if (cnt_q == 8'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			qt_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[126:0], 1'b0};
			rem_q <= ge ? (sh[63:0] - den_q) : sh[63:0];
			qt_q <= {qt_q[126:0], ge};
		end
	end

	assign quo = (den_q == 64'd0 || qt_q[127:64] != 64'd0) ? '1 : qt_q[63:0];
endmodule

// ===== hw/rtl/vrt_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_sqrt
// 64-bit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module vrt_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [63:0] x,
	output logic busy,
	output logic [31:0] root
);
	logic [63:0] x_q, res_q, bit_q;
	logic [5:0] cnt_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// the root of a 64-bit value fits 32 bits
	assign root = res_q[31:0];
endmodule
